// File: rtl/rgbrun_pkg.sv
// Shared types and constants of the RGB565 image run decoder.
package rgbrun_pkg;

   // Widths of the fixed payload fields.
   localparam int unsigned PIXEL_W = 16;
   localparam int unsigned XOUT_W  = 10;
   localparam int unsigned ROW_W   = 16;
   localparam int unsigned REGW_W  = 11;
   localparam int unsigned REGH_W  = 16;

   // Register reset values.
   localparam logic [REGW_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [REGH_W-1:0] HEIGHT_RESET = 16'd480;

   // Register indexes on the configuration port.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Input transaction kinds.
   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_TICK    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // Result kinds.
   typedef enum logic [1:0] {
      ST_PIXEL   = 2'd0,
      ST_DROPPED = 2'd1,
      ST_ENDED   = 2'd2
   } status_type;

   // Command bytes.
   localparam logic [7:0] CMD_LIT_MAX = 8'hf7;
   localparam logic [7:0] CMD_LIT16   = 8'hf8;
   localparam logic [7:0] CMD_PACKED  = 8'hf9;
   localparam logic [7:0] CMD_UPRIGHT = 8'hfa;
   localparam logic [7:0] CMD_UPLEFT  = 8'hfb;
   localparam logic [7:0] CMD_ALT     = 8'hfc;
   localparam logic [7:0] CMD_FILL    = 8'hfd;
   localparam logic [7:0] CMD_UP2     = 8'hfe;
   localparam logic [7:0] CMD_UP1     = 8'hff;

   // High part of a packed run: RGB 3-2-3 bits placed into the top of each field.
   function automatic logic [PIXEL_W-1:0] packed_high(input logic [7:0] b);
      packed_high = {b[7:5], 2'b00, b[4:3], 4'b0000, b[2:0], 2'b00};
   endfunction

   // Low part of a packed run pixel.
   function automatic logic [PIXEL_W-1:0] packed_low(input logic [7:0] c);
      packed_low = {3'b000, c[7:6], 2'b00, c[5:2], 3'b000, c[1:0]};
   endfunction

endpackage

// File: rtl/rgb565_image_run_decoder_core.sv
// Top level of the RGB565 image run decoder: command parser, line store and result stage.
//
// The decoder takes one transaction per clock cycle unless the result side holds it back:
// a compressed stream byte, a drain tick or a restart. It returns at most one result for it,
// via the result and output registers. Parsing state (phase, position, run counters,
// colors) is updated in the cycle of acceptance; the line store, a single synchronous
// memory of three rows of MAX_WIDTH pixels, is read at the same edge for copies from above
// and written at the next edge with the decoded pixel, with forwarding when the read hits
// the pixel still being written. A result register followed by an output register lets the
// decoder take new transactions while a finished result waits. The line store has no reset
// and no clearing pass; it only ever returns pixels written earlier in the image. The
// configuration registers are meant to be written only while the decoder is idle.
module rgb565_image_run_decoder_core #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic [1:0]  req_tuser,    // [1:0] op
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [15:0] pixel, [25:16] pixel_x, [41:26] pixel_y, zero
   output logic [1:0]  rsp_tuser,    // [1:0] status
   output logic        rsp_tlast,    // last pixel of the image
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
   localparam int unsigned WID_W     = $clog2(MAX_WIDTH + 1);
   localparam int unsigned ADDR_W    = COL_W + 2;
   localparam int unsigned MEM_DEPTH = 3 << COL_W;
   localparam int unsigned PW        = rgbrun_pkg::PIXEL_W;
   localparam int unsigned RW        = rgbrun_pkg::ROW_W;

   typedef enum logic [3:0] {
      PH_IDLE, PH_LIT_HI, PH_LIT_LO, PH_LEN, PH_A_LO, PH_A_HI, PH_B_LO, PH_B_HI,
      PH_PK_C0, PH_PK_C1, PH_PK_MORE, PH_PK_SKIP, PH_RUN
   } phase_type;

   // Configuration registers.
   logic [rgbrun_pkg::REGW_W-1:0] image_width_ff;
   logic [rgbrun_pkg::REGH_W-1:0] image_height_ff;

   // Parser state.
   phase_type         phase_ff, phase_in;
   logic [7:0]        command_ff, command_in;
   logic [9:0]        run_remaining_ff, run_remaining_in;
   logic              run_index_ff, run_index_in;
   logic [PW-1:0]     colour_a_ff, colour_a_in;
   logic [PW-1:0]     colour_b_ff, colour_b_in;
   logic [7:0]        held_byte_ff, held_byte_in;
   logic              image_done_ff, image_done_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [1:0]        row_slot_ff, row_slot_in;

   // Result stage: pixel from the line store or an immediate value.
   logic              s1_valid_ff;
   logic              s1_use_mem_ff;
   logic              s1_fwd_ff;
   logic [PW-1:0]     s1_fwd_data_ff;
   logic [PW-1:0]     s1_imm_ff;
   logic              s1_wr_ff;
   logic [ADDR_W-1:0] s1_waddr_ff;
   logic [COL_W-1:0]  s1_x_ff;
   logic [RW-1:0]     s1_y_ff;
   rgbrun_pkg::status_type s1_status_ff;
   logic              s1_last_ff;
   logic [PW-1:0]     s1_pixel;
   logic              s1_go;

   // Output register.
   logic              out_valid_ff;
   logic [PW-1:0]     out_pixel_ff;
   logic [COL_W-1:0]  out_x_ff;
   logic [RW-1:0]     out_y_ff;
   rgbrun_pkg::status_type out_status_ff;
   logic              out_last_ff;

   // Line store.
   logic [PW-1:0]     line_mem [0:MEM_DEPTH-1];
   logic [PW-1:0]     rd_data_ff;

   // Per-transaction decode results.
   logic              accept;
   rgbrun_pkg::op_type op;
   logic [7:0]        b;
   logic              res_valid;
   rgbrun_pkg::status_type res_status;
   logic              res_use_mem;
   logic [PW-1:0]     res_imm;
   logic              emit_req;
   logic [ADDR_W-1:0] rd_addr;
   logic              fwd_hit;

   // Geometry helpers.
   logic [WID_W-1:0]  eff_w;
   logic [RW:0]       eff_h;
   logic [RW:0]       row_inc;
   logic              row_end;
   logic              emit_done;
   logic [1:0]        up_slot1;
   logic [1:0]        up_slot2;

   // Width 0 acts as 1 and widths past the store act as MAX_WIDTH.
   always_comb begin
      if (image_width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(image_width_ff);
      end
      eff_h = (image_height_ff == '0) ? (RW+1)'(1) : {1'b0, image_height_ff};
   end

   assign row_inc   = {1'b0, row_ff} + (RW+1)'(1);
   assign row_end   = (32'(column_ff) + 32'd1) >= 32'(eff_w);
   assign emit_done = row_end && (row_inc >= eff_h);

   // Slots of the rows one and two above the current one.
   assign up_slot1 = (row_slot_ff == 2'd0) ? 2'd2 : row_slot_ff - 2'd1;
   assign up_slot2 = (row_slot_ff == 2'd0) ? 2'd1 : ((row_slot_ff == 2'd1) ? 2'd2 : 2'd0);

   assign s1_go      = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;
   assign op         = rgbrun_pkg::op_type'(req_tuser);
   assign b          = req_tdata;

   assign s1_pixel = s1_use_mem_ff ? (s1_fwd_ff ? s1_fwd_data_ff : rd_data_ff) : s1_imm_ff;

   // The pixel in the result stage is written at this same edge; a read of that entry
   // would see the old contents, so its value is carried along instead.
   assign fwd_hit = s1_valid_ff && s1_wr_ff && (s1_waddr_ff == rd_addr);

   // Parser: next state and the result of the accepted transaction.
   always_comb begin
      phase_in         = phase_ff;
      command_in       = command_ff;
      run_remaining_in = run_remaining_ff;
      run_index_in     = run_index_ff;
      colour_a_in      = colour_a_ff;
      colour_b_in      = colour_b_ff;
      held_byte_in     = held_byte_ff;
      image_done_in    = image_done_ff;
      column_in        = column_ff;
      row_in           = row_ff;
      row_slot_in      = row_slot_ff;
      res_valid        = 1'b0;
      res_status       = rgbrun_pkg::ST_PIXEL;
      res_use_mem      = 1'b0;
      res_imm          = '0;
      emit_req         = 1'b0;
      rd_addr          = {row_slot_ff, column_ff};

      unique case (op)
         rgbrun_pkg::OP_BYTE: begin
            if (image_done_ff) begin
               res_valid  = 1'b1;
               res_status = rgbrun_pkg::ST_ENDED;
            end else begin
               unique case (phase_ff) inside
                  PH_IDLE: begin
                     command_in   = b;
                     run_index_in = 1'b0;
                     if (b <= rgbrun_pkg::CMD_LIT_MAX) begin
                        held_byte_in = b;
                        phase_in     = PH_LIT_HI;
                     end else if (b == rgbrun_pkg::CMD_LIT16) begin
                        phase_in = PH_LIT_LO;
                     end else if (b == rgbrun_pkg::CMD_UPLEFT) begin
                        emit_req = 1'b1;
                        if (row_ff != '0 && column_ff != '0) begin
                           res_use_mem = 1'b1;
                           rd_addr     = {up_slot1, column_ff - COL_W'(1)};
                        end
                     end else if (b == rgbrun_pkg::CMD_UPRIGHT) begin
                        emit_req = 1'b1;
                        if (row_ff != '0 && !row_end) begin
                           res_use_mem = 1'b1;
                           rd_addr     = {up_slot1, column_ff + COL_W'(1)};
                        end
                     end else begin
                        phase_in = PH_LEN;
                     end
                  end
                  PH_LIT_LO: begin
                     held_byte_in = b;
                     phase_in     = PH_LIT_HI;
                  end
                  PH_LIT_HI: begin
                     phase_in = PH_IDLE;
                     emit_req = 1'b1;
                     res_imm  = {b, held_byte_ff};
                  end
                  PH_LEN: begin
                     if (command_ff == rgbrun_pkg::CMD_UP1 ||
                         command_ff == rgbrun_pkg::CMD_UP2) begin
                        run_remaining_in = 10'(b) + 10'd2;
                        phase_in         = PH_RUN;
                     end else if (command_ff == rgbrun_pkg::CMD_FILL) begin
                        run_remaining_in = 10'(b) + 10'd3;
                        phase_in         = PH_A_LO;
                     end else if (command_ff == rgbrun_pkg::CMD_ALT) begin
                        run_remaining_in = (10'(b) + 10'd2) << 1;
                        phase_in         = PH_A_LO;
                     end else begin
                        run_remaining_in = 10'(b);
                        phase_in         = PH_PK_C0;
                     end
                  end
                  PH_A_LO: begin
                     held_byte_in = b;
                     phase_in     = PH_A_HI;
                  end
                  PH_A_HI: begin
                     colour_a_in = {b, held_byte_ff};
                     phase_in    = (command_ff == rgbrun_pkg::CMD_ALT) ? PH_B_LO : PH_RUN;
                  end
                  PH_B_LO: begin
                     held_byte_in = b;
                     phase_in     = PH_B_HI;
                  end
                  PH_B_HI: begin
                     colour_b_in = {b, held_byte_ff};
                     phase_in    = PH_RUN;
                  end
                  PH_PK_C0: begin
                     colour_a_in = rgbrun_pkg::packed_high(b);
                     phase_in    = PH_PK_C1;
                  end
                  PH_PK_C1, PH_PK_MORE: begin
                     if (phase_ff == PH_PK_MORE) begin
                        run_remaining_in = run_remaining_ff - 10'd1;
                     end
                     emit_req = 1'b1;
                     res_imm  = colour_a_ff | rgbrun_pkg::packed_low(b);
                     if (emit_done || run_remaining_in == '0) begin
                        phase_in         = PH_IDLE;
                        run_remaining_in = '0;
                        run_index_in     = 1'b0;
                     end else begin
                        phase_in = row_end ? PH_PK_SKIP : PH_PK_MORE;
                     end
                  end
                  PH_PK_SKIP: begin
                     if (run_remaining_ff != '0) begin
                        run_remaining_in = run_remaining_ff - 10'd1;
                     end
                     if (run_remaining_in == '0) begin
                        phase_in     = PH_IDLE;
                        run_index_in = 1'b0;
                     end
                  end
                  PH_RUN: begin
                     res_valid  = 1'b1;
                     res_status = rgbrun_pkg::ST_DROPPED;
                  end
                  default: begin
                     phase_in         = PH_IDLE;
                     run_remaining_in = '0;
                     run_index_in     = 1'b0;
                  end
               endcase
            end
         end
         rgbrun_pkg::OP_TICK: begin
            if (!image_done_ff && phase_ff == PH_RUN && run_remaining_ff != '0) begin
               emit_req = 1'b1;
               if (command_ff == rgbrun_pkg::CMD_UP1) begin
                  if (row_ff != '0) begin
                     res_use_mem = 1'b1;
                     rd_addr     = {up_slot1, column_ff};
                  end
               end else if (command_ff == rgbrun_pkg::CMD_UP2) begin
                  if (row_ff > RW'(1)) begin
                     res_use_mem = 1'b1;
                     rd_addr     = {up_slot2, column_ff};
                  end
               end else if (command_ff == rgbrun_pkg::CMD_ALT) begin
                  res_imm = run_index_ff ? colour_b_ff : colour_a_ff;
               end else begin
                  res_imm = colour_a_ff;
               end
               run_index_in     = ~run_index_ff;
               run_remaining_in = run_remaining_ff - 10'd1;
               if (row_end || run_remaining_in == '0) begin
                  phase_in         = PH_IDLE;
                  run_remaining_in = '0;
                  run_index_in     = 1'b0;
               end
            end
         end
         rgbrun_pkg::OP_RESTART: begin
            phase_in         = PH_IDLE;
            command_in       = '0;
            run_remaining_in = '0;
            run_index_in     = 1'b0;
            colour_a_in      = '0;
            colour_b_in      = '0;
            held_byte_in     = '0;
            image_done_in    = 1'b0;
            column_in        = '0;
            row_in           = '0;
            row_slot_in      = '0;
         end
         rgbrun_pkg::OP_NONE: begin
         end
         default: begin
         end
      endcase

      // A decoded pixel advances the raster position.
      if (emit_req) begin
         res_valid = 1'b1;
         if (row_end) begin
            column_in   = '0;
            row_in      = row_inc[RW-1:0];
            row_slot_in = (row_slot_ff == 2'd2) ? 2'd0 : row_slot_ff + 2'd1;
            if (emit_done) begin
               image_done_in = 1'b1;
            end
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   // Control state, result stage, output register and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         command_ff       <= '0;
         run_remaining_ff <= '0;
         run_index_ff     <= 1'b0;
         colour_a_ff      <= '0;
         colour_b_ff      <= '0;
         held_byte_ff     <= '0;
         image_done_ff    <= 1'b0;
         column_ff        <= '0;
         row_ff           <= '0;
         row_slot_ff      <= '0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         image_width_ff   <= rgbrun_pkg::WIDTH_RESET;
         image_height_ff  <= rgbrun_pkg::HEIGHT_RESET;
      end else begin
         if (accept) begin
            phase_ff         <= phase_in;
            command_ff       <= command_in;
            run_remaining_ff <= run_remaining_in;
            run_index_ff     <= run_index_in;
            colour_a_ff      <= colour_a_in;
            colour_b_ff      <= colour_b_in;
            held_byte_ff     <= held_byte_in;
            image_done_ff    <= image_done_in;
            column_ff        <= column_in;
            row_ff           <= row_in;
            row_slot_ff      <= row_slot_in;
         end

         if (accept && res_valid) begin
            s1_valid_ff    <= 1'b1;
            s1_use_mem_ff  <= res_use_mem;
            s1_fwd_ff      <= fwd_hit;
            s1_fwd_data_ff <= s1_pixel;
            s1_imm_ff      <= res_imm;
            s1_wr_ff       <= emit_req;
            s1_waddr_ff    <= {row_slot_ff, column_ff};
            s1_x_ff        <= column_ff;
            s1_y_ff        <= row_ff;
            s1_status_ff   <= res_status;
            s1_last_ff     <= emit_req && emit_done;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_go) begin
            out_valid_ff  <= 1'b1;
            out_pixel_ff  <= (s1_status_ff == rgbrun_pkg::ST_PIXEL) ? s1_pixel : '0;
            out_x_ff      <= s1_x_ff;
            out_y_ff      <= s1_y_ff;
            out_status_ff <= s1_status_ff;
            out_last_ff   <= s1_last_ff;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end

         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == rgbrun_pkg::REG_WIDTH) begin
               image_width_ff <= csr_pwdata[rgbrun_pkg::REGW_W-1:0];
            end else begin
               image_height_ff <= csr_pwdata[rgbrun_pkg::REGH_W-1:0];
            end
         end
      end
   end

   // Line store: read at acceptance, write from the result stage.
   always_ff @(posedge clock) begin
      if (accept && res_use_mem) begin
         rd_data_ff <= line_mem[rd_addr];
      end
      if (s1_valid_ff && s1_wr_ff) begin
         line_mem[s1_waddr_ff] <= s1_pixel;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_y_ff, rgbrun_pkg::XOUT_W'(out_x_ff), out_pixel_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == rgbrun_pkg::REG_HEIGHT) ? 32'(image_height_ff)
                                                                : 32'(image_width_ff);

   // The column always addresses a valid entry of a row in the line store.
   assert property (@(posedge clock) disable iff (reset) 32'(column_ff) < 32'(MAX_WIDTH))
      else $error("column outside the line store");

   // Only three rows are kept.
   assert property (@(posedge clock) disable iff (reset) row_slot_ff != 2'd3)
      else $error("invalid row slot");

   // A drained run pending always has pixels left.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RUN |-> run_remaining_ff != '0)
      else $error("empty drained run");

   // The image end closes any run or command in progress.
   assert property (@(posedge clock) disable iff (reset)
      image_done_ff |-> phase_ff == PH_IDLE)
      else $error("command still open after image end");

   // A forwarded pixel is only used for a copy from the line store.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_fwd_ff |-> s1_use_mem_ff)
      else $error("forwarding without a line store read");

endmodule
